// ===== rtl/core/sbfe_pkg.sv =====
// ----------------------------------------------------------------------------
// sbfe_pkg
// Shared types, constants and codes for the serial bootloader frame engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbfe_pkg;

  // default geometry of the flash row and program group
  localparam int ROW_BYTES_DEF   = 64;
  localparam int GROUP_BYTES_DEF = 32;

  // protocol bytes and fixed addresses
  localparam logic [7:0]  SYNC_BYTE     = 8'hC1;
  localparam logic [7:0]  ACK_BYTE      = 8'h4B;
  localparam logic [7:0]  NAK_BYTE      = 8'h4E;
  localparam logic [23:0] EXIT_ADDR     = 24'h7CF8;
  localparam int          FLAG_EE_BIT   = 6;
  localparam int          FLAG_CFG_BIT  = 7;

  // configuration register reset values
  localparam logic [15:0] TIMEOUT_RST   = 16'd1000;
  localparam logic [7:0]  DEVICE_ID_RST = 8'h55;

  // configuration register indexes
  localparam logic REG_TIMEOUT   = 1'b0;
  localparam logic REG_DEVICE_ID = 1'b1;

  // item codes on the input channel
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // frame byte positions
  localparam logic [2:0] FP_FLAG  = 3'd0;
  localparam logic [2:0] FP_HIGH  = 3'd1;
  localparam logic [2:0] FP_LOW   = 3'd2;
  localparam logic [2:0] FP_COUNT = 3'd3;
  localparam logic [2:0] FP_DATA  = 3'd4;

  // result kinds
  typedef enum logic [2:0] {
    KIND_SEND   = 3'd0,
    KIND_EEPROM = 3'd1,
    KIND_CONFIG = 3'd2,
    KIND_ERASE  = 3'd3,
    KIND_LOAD   = 3'd4,
    KIND_PROG   = 3'd5,
    KIND_EXIT   = 3'd6
  } kind_t;

  // what an accepted item leads to
  typedef enum logic [2:0] {
    EV_NONE,
    EV_EXIT,
    EV_SYNC,
    EV_NAK,
    EV_CMD,
    EV_FLASH
  } ev_t;

  // which result the datapath loads into the output register
  typedef enum logic [2:0] {
    EM_EXIT,
    EM_ID,
    EM_ACK,
    EM_NAK,
    EM_CMD,
    EM_ERASE,
    EM_LOAD,
    EM_PROG
  } emit_sel_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HALT,
    ST_EXIT,
    ST_ID,
    ST_ACK,
    ST_NAK,
    ST_CMD,
    ST_ERASE,
    ST_RD,
    ST_LOAD,
    ST_PROG
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic      accept;
    logic      emit;
    emit_sel_t sel;
    logic      last;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    ev_t  ev;
    logic out_free;
    logic grp_done;
    logic more_groups;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/sbfe_ram.sv =====
// ----------------------------------------------------------------------------
// sbfe_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/sbfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbfe_ctrl
// Sequencer: accepts items, then steps through the results each one causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbfe_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sbfe_pkg::dp_status_t sts,
  output sbfe_pkg::ctl_cmd_t        cmd
);
  import sbfe_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.emit   = 1'b0;
    cmd.sel    = EM_ACK;
    cmd.last   = 1'b0;
    in_stall   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (sts.ev)
            EV_EXIT:  state_nxt = ST_EXIT;
            EV_SYNC:  state_nxt = ST_ID;
            EV_NAK:   state_nxt = ST_NAK;
            EV_CMD:   state_nxt = ST_CMD;
            EV_FLASH: state_nxt = ST_ERASE;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_HALT: begin
        // every transfer is taken and dropped
        in_stall = 1'b0;
      end
      ST_EXIT: begin
        cmd.sel  = EM_EXIT;
        cmd.last = 1'b1;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_HALT;
        end
      end
      ST_ID: begin
        cmd.sel = EM_ID;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_ACK;
        end
      end
      ST_ACK: begin
        cmd.sel  = EM_ACK;
        cmd.last = 1'b1;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_NAK: begin
        cmd.sel  = EM_NAK;
        cmd.last = 1'b1;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CMD: begin
        cmd.sel = EM_CMD;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_ACK;
        end
      end
      ST_ERASE: begin
        cmd.sel = EM_ERASE;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.more_groups ? ST_RD : ST_ACK;
        end
      end
      ST_RD: begin
        // row buffer read in flight
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.sel = EM_LOAD;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.grp_done ? ST_PROG : ST_RD;
        end
      end
      ST_PROG: begin
        cmd.sel = EM_PROG;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.more_groups ? ST_RD : ST_ACK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/sbfe_dp.sv =====
// ----------------------------------------------------------------------------
// sbfe_dp
// Datapath: frame registers, checksum, timeout counter, row buffer lanes and
// the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbfe_dp #(
  parameter int ROW_BYTES   = sbfe_pkg::ROW_BYTES_DEF,
  parameter int GROUP_BYTES = sbfe_pkg::GROUP_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [15:0]         cfg_wdata,
  input  wire logic                in_op,
  input  wire logic [7:0]          in_rx_byte,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic [2:0]               out_kind,
  output logic [23:0]              out_address,
  output logic [63:0]              out_data,
  output logic                     out_last,
  input  wire sbfe_pkg::ctl_cmd_t   cmd,
  output sbfe_pkg::dp_status_t      sts
);
  import sbfe_pkg::*;

  localparam int ROWS = (ROW_BYTES + 7) / 8;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DIW  = $clog2(ROW_BYTES + 1);
  localparam int IXW  = $clog2(ROW_BYTES);
  localparam int OFW  = $clog2(ROW_BYTES + GROUP_BYTES + 9);
  localparam int CW   = OFW + 1;

  // configuration registers
  logic [15:0] timeout_r;
  logic [7:0]  device_id_r;

  // frame state
  logic           in_frame_r;
  logic [2:0]     fpos_r;
  logic [7:0]     sum_r;
  logic [8:0]     left_r;
  logic [7:0]     flag_r, high_r, low_r, bbs_r;
  logic [DIW-1:0] di_r;
  logic [15:0]    idle_r;
  logic [ROW_BYTES-1:0] vld_r;

  // flash sequence offsets
  logic [OFW-1:0] off_r, grp_r;

  // output register
  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [23:0] out_addr_r;
  logic [63:0] out_data_r;
  logic        out_last_r;

  logic [7:0]  sum_nxt;
  logic [8:0]  left_dec;
  logic [15:0] idle_inc, lim;
  logic        is_byte, frame_data, row_wr;
  logic [23:0] addr_a;
  logic [7:0]  lane_rd [8];
  logic [7:0]  vmask_r;
  logic [7:0]  vmask_nxt;
  logic [63:0] load_word;
  logic [RAW-1:0] wr_row, rd_row;
  ev_t         ev_d;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      device_id_r <= DEVICE_ID_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT:   timeout_r   <= cfg_wdata;
        REG_DEVICE_ID: device_id_r <= cfg_wdata[7:0];
        default:       ;
      endcase
    end
  end

  // item decode
  assign is_byte    = (in_op == OP_BYTE);
  assign sum_nxt    = sum_r + in_rx_byte;
  assign left_dec   = (left_r != 9'd0) ? left_r - 9'd1 : 9'd0;
  assign idle_inc   = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
  assign lim        = (timeout_r == 16'd0) ? 16'd1 : timeout_r;
  assign frame_data = in_frame_r && (fpos_r == FP_DATA);
  assign row_wr     = cmd.accept && is_byte && frame_data && (di_r < DIW'(ROW_BYTES));
  assign addr_a     = {flag_r, high_r, low_r};

  always_comb begin
    ev_d = EV_NONE;
    if (!is_byte) begin
      if (idle_inc >= lim) ev_d = EV_EXIT;
    end else if (!in_frame_r) begin
      ev_d = (in_rx_byte == SYNC_BYTE) ? EV_SYNC : EV_EXIT;
    end else if (frame_data && (left_dec == 9'd0)) begin
      priority if (sum_nxt != 8'd0)  ev_d = EV_NAK;
      else if (flag_r[FLAG_EE_BIT])  ev_d = EV_CMD;
      else if (flag_r[FLAG_CFG_BIT]) ev_d = EV_CMD;
      else                           ev_d = EV_FLASH;
    end
  end

  // sequence status
  assign sts.ev          = ev_d;
  assign sts.out_free    = !out_valid_r || !out_stall;
  assign sts.grp_done    = (CW'(off_r) + CW'(8)) >= (CW'(grp_r) + CW'(GROUP_BYTES));
  assign sts.more_groups = (CW'(off_r) + CW'(GROUP_BYTES)) <= CW'(ROW_BYTES);

  // control state of the frame parser
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      fpos_r     <= FP_FLAG;
      sum_r      <= 8'd0;
      left_r     <= 9'd0;
      di_r       <= '0;
      idle_r     <= 16'd0;
      vld_r      <= '0;
    end else if (cmd.accept) begin
      if (!is_byte) begin
        idle_r <= idle_inc;
      end else begin
        idle_r <= 16'd0;
        if (!in_frame_r) begin
          if (in_rx_byte == SYNC_BYTE) begin
            in_frame_r <= 1'b1;
            fpos_r     <= FP_FLAG;
            sum_r      <= 8'd0;
          end
        end else begin
          sum_r <= sum_nxt;
          unique case (fpos_r)
            FP_FLAG:  fpos_r <= FP_HIGH;
            FP_HIGH:  fpos_r <= FP_LOW;
            FP_LOW:   fpos_r <= FP_COUNT;
            FP_COUNT: begin
              left_r <= {1'b0, in_rx_byte} + 9'd1;
              di_r   <= '0;
              fpos_r <= FP_DATA;
            end
            default: begin
              if (row_wr) begin
                vld_r[IXW'(di_r)] <= 1'b1;
                di_r              <= di_r + DIW'(1);
              end
              left_r <= left_dec;
              if (left_dec == 9'd0) begin
                fpos_r <= FP_FLAG;
                sum_r  <= 8'd0;
              end
            end
          endcase
        end
      end
    end
  end

  // frame header payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept && is_byte && in_frame_r) begin
      unique case (fpos_r)
        FP_FLAG:  flag_r <= in_rx_byte;
        FP_HIGH:  high_r <= in_rx_byte;
        FP_LOW:   low_r  <= in_rx_byte;
        FP_COUNT: bbs_r  <= in_rx_byte;
        default:  if (left_dec != 9'd0) bbs_r <= in_rx_byte;
      endcase
    end
  end

  // offsets through the row while loads and program groups go out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
      grp_r <= '0;
    end else if (cmd.accept && (ev_d == EV_FLASH)) begin
      off_r <= '0;
      grp_r <= '0;
    end else if (cmd.emit && (cmd.sel == EM_LOAD)) begin
      off_r <= off_r + OFW'(8);
    end else if (cmd.emit && (cmd.sel == EM_PROG)) begin
      grp_r <= off_r;
    end
  end

  // row buffer, one lane per byte of a load word
  assign wr_row = RAW'(di_r >> 3);
  assign rd_row = RAW'(off_r >> 3);

  for (genvar gl = 0; gl < 8; gl++) begin : g_lane
    sbfe_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_lane (
      .clk   (clk),
      .we    (row_wr && (di_r[2:0] == 3'(gl))),
      .waddr (wr_row),
      .wdata (in_rx_byte),
      .raddr (rd_row),
      .rdata (lane_rd[gl])
    );
  end

  // written-entry mask, registered alongside the lane read
  always_comb begin
    logic [OFW:0] ix;
    for (int b = 0; b < 8; b++) begin
      ix = (OFW+1)'(off_r) + (OFW+1)'(b);
      vmask_nxt[b] = (ix < (OFW+1)'(ROW_BYTES)) && vld_r[IXW'(ix)];
    end
  end

  always_ff @(posedge clk) begin
    vmask_r <= vmask_nxt;
  end

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      load_word[8*b +: 8] = vmask_r[b] ? lane_rd[b] : 8'd0;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last_r <= cmd.last;
      unique case (cmd.sel)
        EM_EXIT: begin
          out_kind_r <= KIND_EXIT;
          out_addr_r <= EXIT_ADDR;
          out_data_r <= 64'd0;
        end
        EM_ID: begin
          out_kind_r <= KIND_SEND;
          out_addr_r <= 24'd0;
          out_data_r <= {56'd0, device_id_r};
        end
        EM_ACK: begin
          out_kind_r <= KIND_SEND;
          out_addr_r <= 24'd0;
          out_data_r <= {56'd0, ACK_BYTE};
        end
        EM_NAK: begin
          out_kind_r <= KIND_SEND;
          out_addr_r <= 24'd0;
          out_data_r <= {56'd0, NAK_BYTE};
        end
        EM_CMD: begin
          if (flag_r[FLAG_EE_BIT]) begin
            out_kind_r <= KIND_EEPROM;
            out_addr_r <= {16'd0, high_r};
            out_data_r <= {56'd0, low_r};
          end else begin
            out_kind_r <= KIND_CONFIG;
            out_addr_r <= addr_a;
            out_data_r <= {56'd0, bbs_r};
          end
        end
        EM_ERASE: begin
          out_kind_r <= KIND_ERASE;
          out_addr_r <= addr_a;
          out_data_r <= 64'd0;
        end
        EM_LOAD: begin
          out_kind_r <= KIND_LOAD;
          out_addr_r <= addr_a + 24'(off_r);
          out_data_r <= load_word;
        end
        EM_PROG: begin
          out_kind_r <= KIND_PROG;
          out_addr_r <= addr_a + 24'(grp_r);
          out_data_r <= 64'd0;
        end
        default: begin
          out_kind_r <= KIND_SEND;
          out_addr_r <= 24'd0;
          out_data_r <= 64'd0;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_address = out_addr_r;
  assign out_data    = out_data_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/core/serial_bootloader_frame_engine.sv =====
// ----------------------------------------------------------------------------
// serial_bootloader_frame_engine
// Serial bootloader frame receiver: sync handshake, frame parsing with
// checksum, and EEPROM, configuration and flash row commands.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | in        | in_valid/in_stall  | in_op, in_rx_byte
//  out     | out       | out_valid/out_stall| out_kind, out_address, out_data,
//          |           |                    | out_last
//  cfg     | in        | cfg_we             | cfg_index, cfg_wdata
//
//  one transfer is taken in a cycle while the sequencer is idle; no new item
//  is taken until the results it causes have left the sequencer in turn
//  a good flash frame gives an erase, then a row buffer read and a load for
//  each load word, a program for each group, and the ack
//  synchronous active-low reset; the row buffer reads as zero until written
//  a stall on the output holds the sequencer; the input is stalled meanwhile
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_bootloader_frame_engine #(
  parameter int ROW_BYTES   = sbfe_pkg::ROW_BYTES_DEF,
  parameter int GROUP_BYTES = sbfe_pkg::GROUP_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [23:0]      out_address,
  output logic [63:0]      out_data,
  output logic             out_last
);
  import sbfe_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t sts;

  // sequencer
  sbfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  sbfe_dp #(
    .ROW_BYTES   (ROW_BYTES),
    .GROUP_BYTES (GROUP_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_op       (in_op),
    .in_rx_byte  (in_rx_byte),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_kind    (out_kind),
    .out_address (out_address),
    .out_data    (out_data),
    .out_last    (out_last),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire
